@@ hw/rtl/sks_pkg.sv @@
package sks_pkg;

    localparam int KEY_W  = 16;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 11;

    // operation codes
    localparam logic [ACT_W-1:0] ACT_MEMBER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd0;
    localparam logic [STAT_W-1:0] STAT_HIT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] entry_count;
    } t_out;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_RIGHT,
        SH_LEFT
    } t_shift;

    typedef struct packed {
        logic             cmp;
        t_shift           shift;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SRCH,
        S_APPLY,
        S_OUT
    } t_state;

endpackage

@@ hw/rtl/sks_cell.sv @@
module sks_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sks_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_valid,
    input  logic [sks_pkg::KEY_W-1:0] i_left_key,
    input  logic                     i_left_lt,
    input  logic [sks_pkg::KEY_W-1:0] i_right_key,
    output logic [sks_pkg::KEY_W-1:0] o_key,
    output logic                     o_lt,
    output logic                     o_eq
);
    import sks_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_lt;
    logic             r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_key < i_ctl.key);
            r_eq <= i_valid && (r_key == i_ctl.key);
        end
    end

    // cells at or past the insert/delete point move one place
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.shift)
            SH_RIGHT: begin
                if (!r_lt) begin
                    r_key <= i_left_lt ? i_ctl.key : i_left_key;
                end
            end
            SH_LEFT: begin
                if (!r_lt) begin
                    r_key <= i_right_key;
                end
            end
            SH_NONE: begin
                r_key <= r_key;
            end
            default: begin
                r_key <= r_key;
            end
        endcase
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

@@ hw/rtl/sks_or_tree.sv @@
module sks_or_tree #(
    parameter int N = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_leaf,
    output logic         o_done,
    output logic         o_any
);
    import sks_pkg::*;

    // radix-16 levels, each one registered
    localparam int LOG  = (N > 1) ? $clog2(N) : 1;
    localparam int NSTG = (LOG + 3) / 4;
    localparam int PADN = 1 << (4 * NSTG);

    function automatic int lvl_off(input int s);
        int acc;
        acc = 0;
        for (int j = 0; j < s; j++) begin
            acc = acc + (1 << (4 * (NSTG - j)));
        end
        return acc;
    endfunction

    localparam int TOT = lvl_off(NSTG) + 1;

    wire  [TOT-1:0]  w_tree;
    logic [NSTG:0]   r_vld;

    assign w_tree[PADN-1:0] = PADN'(i_leaf);

    for (genvar gs = 0; gs < NSTG; gs++) begin : g_lvl
        localparam int NOUT = 1 << (4 * (NSTG - gs - 1));
        localparam int IOFF = lvl_off(gs);
        localparam int OOFF = lvl_off(gs + 1);

        logic [NOUT-1:0] r_or;

        always_ff @(posedge i_clk) begin
            for (int n = 0; n < NOUT; n++) begin
                r_or[n] <= |w_tree[IOFF + n * 16 +: 16];
            end
        end

        assign w_tree[OOFF +: NOUT] = r_or;
    end

    // bit 0 lines up with the leaves, bit k with level k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (NSTG + 1)'({r_vld, i_start});
        end
    end

    assign o_done = r_vld[NSTG];
    assign o_any  = w_tree[TOT-1];

endmodule

@@ hw/rtl/sorted_key_set_unit.sv @@
// operation: accept in idle, then compare, search the registered radix-16 match tree,
//   apply the change and load the result into the output register
// one operation at a time: a new input is taken only after the previous result is
//   loaded for output, which waits while the result side holds it off
// reset: synchronous, clears the key count, control and output valid; no clearing pass
module sorted_key_set_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sks_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sks_pkg::t_out o_out_data
);
    import sks_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [STAT_W-1:0] w_status;
    logic [KEY_W-1:0]  r_key;
    logic [ACT_W-1:0]  r_act;
    t_out              r_res;
    t_out              r_out;
    logic              r_out_valid;
    logic              w_out_load;
    t_cell_ctl         w_ctl;

    logic [KEY_W-1:0]  w_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_valid;
    logic              w_tree_done;
    logic              w_present;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [KEY_W-1:0] w_lkey;
        logic             w_llt;
        logic [KEY_W-1:0] w_rkey;

        if (gi == 0) begin : g_first
            assign w_lkey = '0;
            assign w_llt  = 1'b1;
        end else begin : g_mid
            assign w_lkey = w_key[gi-1];
            assign w_llt  = w_lt[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_rkey = w_key[gi];
        end else begin : g_inner
            assign w_rkey = w_key[gi+1];
        end

        assign w_valid[gi] = (CNT_W'(gi) < r_count);

        sks_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_valid     (w_valid[gi]),
            .i_left_key  (w_lkey),
            .i_left_lt   (w_llt),
            .i_right_key (w_rkey),
            .o_key       (w_key[gi]),
            .o_lt        (w_lt[gi]),
            .o_eq        (w_eq[gi])
        );
    end

    sks_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.cmp),
        .i_leaf  (w_eq),
        .o_done  (w_tree_done),
        .o_any   (w_present)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CMP;
            S_CMP:   n_state = S_SRCH;
            S_SRCH:  if (w_tree_done) n_state = S_APPLY;
            S_APPLY: n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_ctl.cmp   = (r_state == S_CMP);
        w_ctl.key   = r_key;
        w_ctl.shift = SH_NONE;
        w_status    = STAT_MISS;
        n_count     = r_count;
        if (r_state == S_APPLY) begin
            unique case (r_act)
                ACT_MEMBER: begin
                    w_status = w_present ? STAT_HIT : STAT_MISS;
                end
                ACT_INSERT: begin
                    if (w_present) begin
                        w_status = STAT_MISS;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        w_status = STAT_FULL;
                    end else begin
                        w_status    = STAT_HIT;
                        w_ctl.shift = SH_RIGHT;
                        n_count     = r_count + 1'b1;
                    end
                end
                ACT_DELETE: begin
                    if (w_present) begin
                        w_status    = STAT_HIT;
                        w_ctl.shift = SH_LEFT;
                        n_count     = r_count - 1'b1;
                    end
                end
                default: begin
                    w_status = STAT_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_key <= i_in_data.key;
            r_act <= i_in_data.action;
        end
        if (r_state == S_APPLY) begin
            r_res.status      <= w_status;
            r_res.entry_count <= ECNT_W'(n_count);
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result shown without a finished operation");

    a_apply_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $past(w_tree_done))
        else $error("apply before match tree settled");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(r_state == S_APPLY))
        else $error("key count changed outside apply");

    a_shift_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.shift != SH_NONE) |=> (r_res.status == STAT_HIT))
        else $error("store moved without a completed insert or delete");

endmodule

@@ tb/tb_sorted_key_set_unit.sv @@
module tb_sorted_key_set_unit;
    import sks_pkg::*;

    localparam int CAPACITY    = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_ready;
    t_out  o_out_data;

    sorted_key_set_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // shadow copy of the sorted store
    logic [KEY_W-1:0] held_keys [CAPACITY];
    int               held_count;

    t_out results_due[$];
    t_in  ops_due[$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // applies one operation to the shadow store and returns the reply it should give
    function automatic t_out apply_set_op(input t_in op);
        t_out reply;
        int   pos;
        logic present;
        pos = 0;
        while (pos < held_count && held_keys[pos] < op.key)
            pos++;
        present = (pos < held_count) && (held_keys[pos] == op.key);
        reply.status = STAT_MISS;
        case (op.action)
            ACT_MEMBER: begin
                if (present)
                    reply.status = STAT_HIT;
            end
            ACT_INSERT: begin
                if (!present) begin
                    if (held_count >= CAPACITY) begin
                        reply.status = STAT_FULL;
                    end else begin
                        for (int i = held_count; i > pos; i--)
                            held_keys[i] = held_keys[i-1];
                        held_keys[pos] = op.key;
                        held_count++;
                        reply.status = STAT_HIT;
                    end
                end
            end
            ACT_DELETE: begin
                if (present) begin
                    for (int i = pos; i < held_count - 1; i++)
                        held_keys[i] = held_keys[i+1];
                    held_count--;
                    reply.status = STAT_HIT;
                end
            end
            default: ;
        endcase
        reply.entry_count = ECNT_W'(held_count);
        return reply;
    endfunction

    // mix of held keys, a sparse pool that collides often, and full-range keys
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 35 && held_count > 0)
            return held_keys[$urandom_range(held_count - 1)];
        else if (r < 70)
            return KEY_W'($urandom_range(47) * 1361);
        else
            return KEY_W'($urandom);
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int ins_pct, input int del_pct);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return ACT_UNUSED;
        else if (r < 4 + ins_pct)
            return ACT_INSERT;
        else if (r < 4 + ins_pct + del_pct)
            return ACT_DELETE;
        else
            return ACT_MEMBER;
    endfunction

    task automatic offer_op(input logic [ACT_W-1:0] action, input logic [KEY_W-1:0] key);
        t_in op;
        op.action = action;
        op.key    = key;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        results_due.push_back(apply_set_op(op));
        ops_due.push_back(op);
    endtask

    task automatic check_reply(input t_out got);
        t_out want;
        t_in  op;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result status %0d count %0d",
                     $time, got.status, got.entry_count);
            mismatches++;
            return;
        end
        want = results_due.pop_front();
        op   = ops_due.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: action %0d key %h status expected %0d actual %0d",
                     $time, op.action, op.key, want.status, got.status);
            mismatches++;
        end
        if (got.entry_count !== want.entry_count) begin
            $display("%0t: action %0d key %h entry_count expected %0d actual %0d",
                     $time, op.action, op.key, want.entry_count, got.entry_count);
            mismatches++;
        end
    endtask

    // result side: check each transaction, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_reply(o_out_data);
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        offer_op(ACT_MEMBER, 16'h0000);
        offer_op(ACT_DELETE, 16'hffff);
        offer_op(ACT_UNUSED, 16'hffff);
        offer_op(ACT_INSERT, 16'h0000);
        offer_op(ACT_INSERT, 16'hffff);
        offer_op(ACT_INSERT, 16'h8000);
        offer_op(ACT_INSERT, 16'h8000);
        offer_op(ACT_MEMBER, 16'h0000);
        offer_op(ACT_MEMBER, 16'hffff);
        offer_op(ACT_MEMBER, 16'h7fff);
        offer_op(ACT_INSERT, 16'h7fff);
        offer_op(ACT_MEMBER, 16'h7fff);
        offer_op(ACT_DELETE, 16'h8000);
        offer_op(ACT_DELETE, 16'h8000);
        offer_op(ACT_UNUSED, 16'h5a5a);
        offer_op(ACT_INSERT, 16'h0001);
        offer_op(ACT_DELETE, 16'h0000);
        offer_op(ACT_DELETE, 16'hffff);
        offer_op(ACT_MEMBER, 16'h0001);
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
            offer_op(pick_action(40, 30), pick_key());
    endtask

    // result side holds off while the sender keeps offering
    task automatic test_output_backpressure();
        hold_cycles = 300;
        for (int n = 0; n < 12; n++)
            offer_op(pick_action(40, 30), pick_key());
    endtask

    // grows the store to capacity, then exercises the full cases
    task automatic test_full_store();
        while (held_count < CAPACITY)
            offer_op(ACT_INSERT, KEY_W'($urandom));
        for (int n = 0; n < 6; n++)
            offer_op(ACT_INSERT, KEY_W'($urandom));
        offer_op(ACT_INSERT, held_keys[0]);
        offer_op(ACT_INSERT, held_keys[CAPACITY-1]);
        offer_op(ACT_MEMBER, held_keys[CAPACITY/2]);
        offer_op(ACT_UNUSED, 16'ha5a5);
        offer_op(ACT_DELETE, held_keys[0]);
        offer_op(ACT_INSERT, 16'hffff);
        offer_op(ACT_INSERT, 16'h0000);
        offer_op(ACT_INSERT, 16'h0001);
    endtask

    task automatic test_shrink(input int count);
        for (int n = 0; n < count; n++)
            offer_op(pick_action(20, 50), pick_key());
    endtask

    initial begin
        held_count = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_out_ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 69;
        test_directed();
        test_random_mix(220);

        send_idle_pct = 69;
        recv_idle_pct = 24;
        test_random_mix(220);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_store();
        test_shrink(200);

        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
